/* design/stack_with_indexed_insert_remove_macros.svh */
// ----------------------------------------------------------------------------
// stack with indexed insert/remove: assertion macros
// shared helpers for concurrent checks on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_INDEXED_INSERT_REMOVE_MACROS_SVH
`define STACK_WITH_INDEXED_INSERT_REMOVE_MACROS_SVH

// same-cycle implication
`define STKIR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stkir check failed");

// next-cycle implication
`define STKIR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stkir check failed");

`endif

/* design/stkir_pkg.sv */
// ----------------------------------------------------------------------------
// stkir_pkg
// shared constants, operation and error codes, controller command type
// ----------------------------------------------------------------------------
package stkir_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;

    // operation codes
    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_INSERT = 2'd2;
    localparam logic [1:0] ACT_REMOVE = 2'd3;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;
    localparam logic [1:0] ERR_INDEX = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;  // capture operands of an accepted transaction
        logic exec;  // apply the operation and capture the result
    } cmd_t;

endpackage

/* design/stkir_ctrl.sv */
// ----------------------------------------------------------------------------
// stkir_ctrl
// two-state sequencer: accept a transaction, then execute it
// ----------------------------------------------------------------------------
module stkir_ctrl
    import stkir_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

endmodule

/* design/stkir_dp.sv */
// ----------------------------------------------------------------------------
// stkir_dp
// shifting register file, fill count, operand and result registers
// ----------------------------------------------------------------------------
module stkir_dp
    import stkir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cmd_t                            cmd,
    input  logic [1:0]                      action,
    input  logic signed [DATA_W-1:0]        value,
    input  logic [POS_W-1:0]                position,
    output logic signed [DATA_W-1:0]        data,
    output logic                            data_valid,
    output logic [1:0]                      error,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // slot 0 is the top of the stack
    logic signed [DATA_W-1:0] slot_reg [DEPTH];
    logic signed [DATA_W-1:0] from_above [DEPTH];
    logic signed [DATA_W-1:0] from_below [DEPTH];

    logic [1:0]               act_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [CW-1:0]            fill_reg;
    logic [CW-1:0]            fill_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     dv_reg;
    logic                     dv_next;
    logic [1:0]               err_reg;
    logic [1:0]               err_next;

    logic          full;
    logic          empty;
    logic          pos_lt_fill;
    logic          ins_en;
    logic          rem_en;
    logic [AW-1:0] idx;

    always_comb
    begin
        full        = (fill_reg == CW'(DEPTH));
        empty       = (fill_reg == '0);
        pos_lt_fill = (CMPW'(pos_reg) < CMPW'(fill_reg));
        ins_en      = 1'b0;
        rem_en      = 1'b0;
        idx         = '0;
        err_next    = ERR_OK;
        dv_next     = 1'b0;
        data_next   = '0;
        fill_next   = fill_reg;
        case (act_reg)
            ACT_PUSH:
            begin
                if (full)
                    err_next = ERR_FULL;
                else
                begin
                    ins_en    = 1'b1;
                    fill_next = fill_reg + CW'(1);
                end
            end
            ACT_POP:
            begin
                if (empty)
                begin
                    err_next  = ERR_EMPTY;
                    data_next = '1;
                end
                else
                begin
                    rem_en    = 1'b1;
                    dv_next   = 1'b1;
                    data_next = slot_reg[idx];
                    fill_next = fill_reg - CW'(1);
                end
            end
            ACT_INSERT:
            begin
                // past the count: lands just above the bottom entry
                if (pos_lt_fill)
                    idx = pos_reg[AW-1:0];
                else if (!empty)
                    idx = AW'(fill_reg - CW'(1));
                if (full)
                    err_next = ERR_FULL;
                else
                begin
                    ins_en    = 1'b1;
                    fill_next = fill_reg + CW'(1);
                end
            end
            ACT_REMOVE:
            begin
                idx = pos_reg[AW-1:0];
                if ((pos_reg == '0) || !pos_lt_fill)
                begin
                    err_next = ERR_INDEX;
                    idx      = '0;
                end
                else
                begin
                    rem_en    = 1'b1;
                    dv_next   = 1'b1;
                    data_next = slot_reg[idx];
                    fill_next = fill_reg - CW'(1);
                end
            end
            default:
            begin
                err_next = ERR_OK;
            end
        endcase
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            val_reg <= value;
            pos_reg <= position;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            data_reg <= data_next;
            dv_reg   <= dv_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (cmd.exec)
            fill_reg <= fill_next;
    end

    // each slot loads from its neighbors or from the operand value
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        if (i == 0)
        begin : g_top
            assign from_above[i] = val_reg;
        end
        else
        begin : g_mid
            assign from_above[i] = slot_reg[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bot
            assign from_below[i] = slot_reg[i];
        end
        else
        begin : g_upper
            assign from_below[i] = slot_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.exec)
            begin
                if (ins_en)
                begin
                    if (AW'(i) == idx)
                        slot_reg[i] <= val_reg;
                    else if (AW'(i) > idx)
                        slot_reg[i] <= from_above[i];
                end
                else if (rem_en && (AW'(i) >= idx))
                    slot_reg[i] <= from_below[i];
            end
        end
    end

    assign data       = data_reg;
    assign data_valid = dv_reg;
    assign error      = err_reg;
    assign count      = fill_reg;

endmodule

/* design/stack_with_indexed_insert_remove.sv */
// ----------------------------------------------------------------------------
// stack_with_indexed_insert_remove
// bounded stack of signed words with push, pop, insert and remove by index
// ----------------------------------------------------------------------------
// a transaction is taken when start is high and busy is low. the block then
// executes it in the execute state (busy high) and shows the result for
// exactly one cycle with done high, the cycle after. a transaction therefore
// has a step to capture the operands and a step in which the register file
// shifts every slot at or below the index by one place. start is taken again
// in the same cycle that done is shown. the receiver cannot stall: done
// pulses once per transaction and the result must be taken in that cycle.
// count always reports the entries stored after the last completed
// transaction. index 0 is the top of the stack.
// ----------------------------------------------------------------------------
module stack_with_indexed_insert_remove
    import stkir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic signed [DATA_W-1:0]    value,
    input  logic [POS_W-1:0]            position,
    output logic                        done,
    output logic signed [DATA_W-1:0]    data,
    output logic                        data_valid,
    output logic [1:0]                  error,
    output logic [$clog2(DEPTH+1)-1:0]  count
);

    // command bus from sequencer to datapath
    cmd_t cmd;

    // sequencer: idle, then the execute state for each transaction
    stkir_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // shifting register file plus fill count and result registers
    stkir_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .action     (action),
        .value      (value),
        .position   (position),
        .data       (data),
        .data_valid (data_valid),
        .error      (error),
        .count      (count)
    );

endmodule

/* design/stkir_chk.sv */
// ----------------------------------------------------------------------------
// stkir_chk
// port-level checks on transaction timing and result consistency
// ----------------------------------------------------------------------------
`include "stack_with_indexed_insert_remove_macros.svh"

module stkir_chk
    import stkir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        data_valid,
    input logic [1:0]                  error,
    input logic [$clog2(DEPTH+1)-1:0]  count
);

    localparam int CW = $clog2(DEPTH + 1);

    // an accepted transaction executes in the next cycle
    `STKIR_ASSERT_NXT(a_accept_busy, start && !busy, busy)

    // execution always finishes in the next cycle with a result
    `STKIR_ASSERT_NXT(a_busy_done, busy, done && !busy)

    // a word is only returned on success
    `STKIR_ASSERT_IMP(a_valid_ok, done && data_valid, error == ERR_OK)

    // a full error leaves the stack full
    `STKIR_ASSERT_IMP(a_full_count, done && (error == ERR_FULL), count == CW'(DEPTH))

endmodule

bind stack_with_indexed_insert_remove stkir_chk #(
    .DEPTH (DEPTH)
) u_stkir_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .data_valid (data_valid),
    .error      (error),
    .count      (count)
);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench for stack_with_indexed_insert_remove
// drives push, pop, insert and remove transactions, keeps a shadow stack and
// compares every result field against the value it predicts
// ----------------------------------------------------------------------------
module testbench;
    import stkir_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 4;

    // one expected result of a transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] word;
        logic                     word_valid;
        logic [1:0]               code;
        logic [CNT_W-1:0]         fill;
    } stack_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [1:0]               action = ACT_PUSH;
    logic signed [DATA_W-1:0] value = '0;
    logic [POS_W-1:0]         position = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] data;
    logic                     data_valid;
    logic [1:0]               error;
    logic [CNT_W-1:0]         count;

    // shadow of the stack contents, element 0 is the top word
    logic signed [DATA_W-1:0] shadow_words[$];
    // results predicted for accepted transactions, oldest first
    stack_result_t            pending_results[$];

    int mismatch_count   = 0;
    int cycle_count      = 0;
    int sender_idle_pct  = 0;

    stack_with_indexed_insert_remove #(
        .DEPTH      (STACK_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .value      (value),
        .position   (position),
        .done       (done),
        .data       (data),
        .data_valid (data_valid),
        .error      (error),
        .count      (count)
    );

    always #5 clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // applies one transaction to the shadow stack and returns its result
    function automatic stack_result_t stack_next_result(
        input logic [1:0]               op,
        input logic signed [DATA_W-1:0] word,
        input logic [POS_W-1:0]         idx
    );
        stack_result_t r;
        int            slot;
        int            held;
        r    = '0;
        held = shadow_words.size();
        case (op)
            ACT_PUSH:
            begin
                if (held >= STACK_DEPTH)
                    r.code = ERR_FULL;
                else
                    shadow_words.push_front(word);
            end
            ACT_POP:
            begin
                if (held == 0)
                begin
                    // empty pop reports all ones with no valid word
                    r.word = -1;
                    r.code = ERR_EMPTY;
                end
                else
                begin
                    r.word       = shadow_words.pop_front();
                    r.word_valid = 1'b1;
                end
            end
            ACT_INSERT:
            begin
                if (held >= STACK_DEPTH)
                    r.code = ERR_FULL;
                else
                begin
                    // an index past the end lands just above the bottom word
                    if (int'(idx) < held)
                        slot = int'(idx);
                    else
                        slot = (held > 0) ? held - 1 : 0;
                    shadow_words.insert(slot, word);
                end
            end
            ACT_REMOVE:
            begin
                // the top word and anything past the end cannot be removed
                if (idx == 0 || int'(idx) >= held)
                    r.code = ERR_INDEX;
                else
                begin
                    r.word       = shadow_words[idx];
                    r.word_valid = 1'b1;
                    shadow_words.delete(int'(idx));
                end
            end
            default:
            begin
                r.code = ERR_OK;
            end
        endcase
        r.fill = CNT_W'(shadow_words.size());
        return r;
    endfunction

    // sends one transaction, predicts it once taken, then maybe idles a little
    task automatic send_op(
        input logic [1:0]               op,
        input logic signed [DATA_W-1:0] word,
        input logic [POS_W-1:0]         idx
    );
        start    <= 1'b1;
        action   <= op;
        value    <= word;
        position <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(stack_next_result(op, word, idx));
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            // a random idle gap keeps start low while the block waits idle
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // result checker, done marks the single cycle a result is shown
    always @(posedge clk)
    begin
        stack_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction outstanding: data %0d count %0d",
                       data, count);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (data !== exp_r.word)
                begin
                    $error("data: expected %0d, actual %0d", exp_r.word, data);
                    mismatch_count++;
                end
                if (data_valid !== exp_r.word_valid)
                begin
                    $error("data_valid: expected %0d, actual %0d",
                           exp_r.word_valid, data_valid);
                    mismatch_count++;
                end
                if (error !== exp_r.code)
                begin
                    $error("error: expected %0d, actual %0d", exp_r.code, error);
                    mismatch_count++;
                end
                if (count !== exp_r.fill)
                begin
                    $error("count: expected %0d, actual %0d", exp_r.fill, count);
                    mismatch_count++;
                end
            end
        end
    end

    // empty stack and single entry corner cases
    task automatic test_empty_stack_cases();
        sender_idle_pct = 0;
        send_op(ACT_POP, 32'sd0, 8'd0);
        send_op(ACT_REMOVE, 32'sd0, 8'd0);
        send_op(ACT_REMOVE, 32'sd0, 8'd255);
        // insert into an empty stack becomes the only entry
        send_op(ACT_INSERT, 32'h1234_5678, 8'd255);
        send_op(ACT_REMOVE, 32'sd0, 8'd0);
        send_op(ACT_REMOVE, 32'sd0, 8'd1);
        send_op(ACT_POP, 32'sd0, 8'd0);
    endtask

    // extreme words, insert past the end, removes at both ends of the range
    task automatic test_extreme_words_and_indexes();
        sender_idle_pct = 0;
        send_op(ACT_PUSH, 32'h7fff_ffff, 8'd0);
        send_op(ACT_PUSH, 32'h8000_0000, 8'd0);
        send_op(ACT_INSERT, 32'h0000_0000, 8'd0);
        send_op(ACT_INSERT, 32'hffff_ffff, 8'd1);
        send_op(ACT_INSERT, 32'h5555_aaaa, 8'd200);
        send_op(ACT_PUSH, 32'haaaa_5555, 8'd0);
        // bottom entry, then an index equal to the count
        send_op(ACT_REMOVE, 32'sd0, 8'd5);
        send_op(ACT_REMOVE, 32'sd0, 8'd5);
        send_op(ACT_REMOVE, 32'sd0, 8'd1);
        send_op(ACT_REMOVE, 32'sd0, 8'd0);
        send_op(ACT_POP, 32'sd0, 8'd0);
        send_op(ACT_POP, 32'sd0, 8'd0);
        send_op(ACT_POP, 32'sd0, 8'd0);
        send_op(ACT_POP, 32'sd0, 8'd0);
    endtask

    // random traffic that swings between filling and draining the stack
    task automatic test_random_ops(input int n_ops, input int idle_pct);
        logic [1:0]               op;
        logic signed [DATA_W-1:0] word;
        logic [POS_W-1:0]         idx;
        int                       roll;
        bit                       growing;
        growing         = 1'b1;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < n_ops; i++)
        begin
            // re-pick the direction every 24 transactions to hit full and empty
            if (i % 24 == 0)
                growing = $urandom_range(0, 99) < 55;
            roll = $urandom_range(0, 99);
            if (growing)
                op = (roll < 35) ? ACT_PUSH : (roll < 70) ? ACT_INSERT :
                     (roll < 85) ? ACT_POP : ACT_REMOVE;
            else
                op = (roll < 15) ? ACT_PUSH : (roll < 30) ? ACT_INSERT :
                     (roll < 65) ? ACT_POP : ACT_REMOVE;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                word = 32'h8000_0000;
            else if (roll < 8)
                word = 32'h7fff_ffff;
            else if (roll < 12)
                word = 32'hffff_ffff;
            else if (roll < 15)
                word = '0;
            else
                word = $urandom;
            // mostly indexes near the live range, sometimes anywhere
            if ($urandom_range(0, 99) < 85)
                idx = POS_W'($urandom_range(0, STACK_DEPTH + 1));
            else
                idx = POS_W'($urandom_range(0, 255));
            send_op(op, word, idx);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack_cases();
        test_extreme_words_and_indexes();
        test_random_ops(600, 0);
        test_random_ops(600, 75);
        test_random_ops(600, 8);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
